// ----- design/rhsm_pkg.sv -----
// Shared constants, types and modular-arithmetic helpers for the rolling hash matcher.
package rhsm_pkg;

	// Sizes
	localparam int unsigned MAX_PATTERN = 256;
	localparam int unsigned MAX_TEXT    = 1048576;
	localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
	localparam int POS_W  = $clog2(MAX_TEXT + 1);
	localparam int SLOT_W = $clog2(MAX_PATTERN);
	localparam int HASH_W = 30;
	localparam int WIDE_W = 39;

	typedef logic [7:0]        byte_t;
	typedef logic [LEN_W-1:0]  len_t;
	typedef logic [POS_W-1:0]  pos_t;
	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [HASH_W-1:0] hash_t;
	typedef logic [WIDE_W-1:0] wide_t;

	// Hash constants
	localparam hash_t       HASH_MOD  = 30'd1000000009;
	localparam logic [8:0]  HASH_BASE = 9'd311;
	localparam logic [31:0] MOD_X1    = 32'(HASH_MOD);
	localparam logic [31:0] MOD_X2    = 32'(64'(HASH_MOD) * 64'd2);
	localparam logic [31:0] MOD_X3    = 32'(64'(HASH_MOD) * 64'd3);

	// Fold tables: weight of the bits above bit 29, already reduced mod p
	typedef logic [15:0][HASH_W-1:0] fold_lo_t;
	typedef logic [31:0][HASH_W-1:0] fold_hi_t;

	function automatic fold_lo_t make_fold_lo();
		fold_lo_t t;
		for (int k = 0; k < 16; k++) begin
			t[k] = HASH_W'((64'(k) << 30) % 64'(HASH_MOD));
		end
		return t;
	endfunction

	function automatic fold_hi_t make_fold_hi();
		fold_hi_t t;
		for (int k = 0; k < 32; k++) begin
			t[k] = HASH_W'((64'(k) << 34) % 64'(HASH_MOD));
		end
		return t;
	endfunction

	localparam fold_lo_t FOLD_LO = make_fold_lo();
	localparam fold_hi_t FOLD_HI = make_fold_hi();

	// v mod p for any 39-bit v: fold high bits through tables, then up to 3p off
	function automatic hash_t reduce_mod(wide_t v);
		logic [31:0] s;
		hash_t       r;
		s = 32'(v[29:0]) + 32'(FOLD_LO[v[33:30]]) + 32'(FOLD_HI[v[38:34]]);
		if (s >= MOD_X3) begin
			r = HASH_W'(s - MOD_X3);
		end else if (s >= MOD_X2) begin
			r = HASH_W'(s - MOD_X2);
		end else if (s >= MOD_X1) begin
			r = HASH_W'(s - MOD_X1);
		end else begin
			r = HASH_W'(s);
		end
		return r;
	endfunction

	// (x * base + add) mod p, x < p, add <= p + 255
	function automatic hash_t mac_mod(hash_t x, logic [HASH_W:0] add);
		return reduce_mod(wide_t'(x) * wide_t'(HASH_BASE) + wide_t'(add));
	endfunction

endpackage

// ----- design/rhsm_in_if.sv -----
// Input channel: one pattern or text byte per transfer.
interface rhsm_in_if import rhsm_pkg::*; ();
	logic  valid;
	logic  ready;
	logic  req_type;
	byte_t data_byte;
	logic  first_of_run;

	modport source(output valid, output req_type, output data_byte, output first_of_run,
		input ready);
	modport sink(input valid, input req_type, input data_byte, input first_of_run,
		output ready);
endinterface

// ----- design/rhsm_out_if.sv -----
// Output channel: one match start position per transfer.
interface rhsm_out_if import rhsm_pkg::*; ();
	logic valid;
	logic ready;
	pos_t match_start;

	modport source(output valid, output match_start, input ready);
	modport sink(input valid, input match_start, output ready);
endinterface

// ----- design/rhsm_delay_line.sv -----
// Text byte delay line: circular RAM, one write and one registered read per cycle.
module rhsm_delay_line import rhsm_pkg::*; (
	input  logic  clk,
	input  logic  wr_en,
	input  slot_t wr_addr,
	input  byte_t wr_data,
	input  logic  rd_en,
	input  slot_t rd_addr,
	output byte_t rd_data
);

	byte_t mem [MAX_PATTERN];

	// Read returns the old entry when both ports hit the same slot
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- design/rolling_hash_substring_match.sv -----
// Rabin-Karp matcher (base 311, mod 1000000009). Pattern bytes (req_type 0) build the
// pattern hash and 311^length; text bytes (req_type 1) roll a window hash and each full
// window whose hash equals the pattern hash yields its 1-based start position. One byte
// is taken every cycle until a stalled output fills the pipe; result valid is registered
// after the capture, product and reduction stages. The rate is set by the window hash
// update, one multiply-by-311 and table fold mod p in the last stage, and by the 256 x 8
// delay line RAM with one write and one read port. The delay line needs no clearing after
// reset. A stalled output stops the pipe only once every stage ahead of it is full.
module rolling_hash_substring_match import rhsm_pkg::*; (
	input logic clk,
	input logic arst_n,
	rhsm_in_if.sink item,
	rhsm_out_if.source result
);

	typedef struct packed {
		logic  restart;
		byte_t data;
		logic  emit_ok;
		pos_t  start;
		hash_t ph;
	} item_t;

	// Pattern and text state
	hash_t ph_q;
	hash_t bp_q;
	len_t  plen_q;
	logic  tl_q;
	pos_t  pos_q;
	logic  pend_q;
	hash_t win_q;

	// Pipeline
	logic  s1_v, s2_v, s3_v;
	item_t it_s1, it_s2, it_s3;
	logic  has_leave_s1;
	hash_t bp_s1;
	byte_t leave_s1;
	wide_t prod_s2;
	hash_t rem_s3;

	logic  out_v_q;
	pos_t  out_d_q;

	// Flow control
	logic out_free, en1, en2, en3, in_fire;

	assign out_free   = !out_v_q || result.ready;
	assign en3        = !s3_v || out_free;
	assign en2        = !s2_v || en3;
	assign en1        = !s1_v || en2;
	assign item.ready = en1;
	assign in_fire    = item.valid && en1;

	// Pattern byte path
	len_t  p_len;
	hash_t p_ph, p_bp, p_ph_next, p_bp_next;
	logic  p_tl, p_full;

	assign p_len     = item.first_of_run ? '0 : plen_q;
	assign p_ph      = item.first_of_run ? '0 : ph_q;
	assign p_bp      = item.first_of_run ? hash_t'(1) : bp_q;
	assign p_tl      = item.first_of_run ? 1'b0 : tl_q;
	assign p_full    = p_len >= len_t'(MAX_PATTERN);
	assign p_ph_next = mac_mod(p_ph, (HASH_W + 1)'(item.data_byte));
	assign p_bp_next = mac_mod(p_bp, '0);

	// Text byte path
	pos_t  t_pos, t_pos_next;
	logic  t_sat, t_go, t_leave, t_emit;
	slot_t t_rd_addr;
	item_t t_item;

	assign t_pos      = item.first_of_run ? '0 : pos_q;
	assign t_pos_next = t_pos + pos_t'(1);
	assign t_sat      = t_pos >= pos_t'(MAX_TEXT);
	assign t_go       = in_fire && item.req_type && !t_sat;
	assign t_leave    = (plen_q != '0) && (t_pos >= pos_t'(plen_q));
	assign t_emit     = (plen_q != '0) && !tl_q && (t_pos_next >= pos_t'(plen_q));
	assign t_rd_addr  = t_pos[SLOT_W-1:0] - plen_q[SLOT_W-1:0];

	always_comb begin
		t_item.restart = item.first_of_run || pend_q;
		t_item.data    = item.data_byte;
		t_item.emit_ok = t_emit;
		t_item.start   = t_pos_next - pos_t'(plen_q) + pos_t'(1);
		t_item.ph      = ph_q;
	end

	rhsm_delay_line u_delay_line (
		.clk     (clk),
		.wr_en   (t_go),
		.wr_addr (t_pos[SLOT_W-1:0]),
		.wr_data (item.data_byte),
		.rd_en   (en1),
		.rd_addr (t_rd_addr),
		.rd_data (leave_s1)
	);

	// Front state, updated at each input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= '0;
			bp_q   <= hash_t'(1);
			plen_q <= '0;
			tl_q   <= 1'b0;
			pos_q  <= '0;
			pend_q <= 1'b0;
		end else if (in_fire) begin
			if (!item.req_type) begin
				pos_q  <= '0;
				pend_q <= 1'b1;
				if (p_full) begin
					ph_q   <= p_ph;
					bp_q   <= p_bp;
					plen_q <= p_len;
					tl_q   <= 1'b1;
				end else begin
					ph_q   <= p_ph_next;
					bp_q   <= p_bp_next;
					plen_q <= p_len + len_t'(1);
					tl_q   <= p_tl;
				end
			end else if (!t_sat) begin
				pos_q  <= t_pos_next;
				pend_q <= 1'b0;
			end
		end
	end

	// Pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
			s2_v <= 1'b0;
			s3_v <= 1'b0;
		end else begin
			if (en1) begin
				s1_v <= t_go;
			end
			if (en2) begin
				s2_v <= s1_v;
			end
			if (en3) begin
				s3_v <= s2_v;
			end
		end
	end

	// Pipeline payload: capture, leaving-byte product, reduction
	always_ff @(posedge clk) begin
		if (en1) begin
			it_s1        <= t_item;
			has_leave_s1 <= t_leave;
			bp_s1        <= bp_q;
		end
		if (en2) begin
			it_s2   <= it_s1;
			prod_s2 <= wide_t'(has_leave_s1 ? leave_s1 : byte_t'(0)) * wide_t'(bp_s1);
		end
		if (en3) begin
			it_s3  <= it_s2;
			rem_s3 <= reduce_mod(prod_s2);
		end
	end

	// Window hash update and compare
	hash_t w_base, w_new;
	logic  w_match, s3_take;

	assign s3_take = s3_v && out_free;
	assign w_base  = it_s3.restart ? '0 : win_q;
	assign w_new   = mac_mod(w_base,
		(HASH_W + 1)'(HASH_MOD - rem_s3) + (HASH_W + 1)'(it_s3.data));
	assign w_match = it_s3.emit_ok && (w_new == it_s3.ph);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q   <= '0;
			out_v_q <= 1'b0;
		end else if (out_free) begin
			out_v_q <= s3_v && w_match;
			if (s3_v) begin
				win_q <= w_new;
			end
		end
	end

	// Result data
	always_ff @(posedge clk) begin
		if (s3_take) begin
			out_d_q <= it_s3.start;
		end
	end

	assign result.valid       = out_v_q;
	assign result.match_start = out_d_q;

endmodule

// ----- design/rhsm_checker.sv -----
// Port-level checks for the rolling hash matcher, bound to the top level.
module rhsm_checker import rhsm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	input logic item_ready,
	input logic result_valid,
	input logic result_ready,
	input pos_t match_start
);

	// A stalled result keeps its value
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(match_start))
		else $error("result changed while stalled");

	// Start positions are 1-based
	a_start_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> match_start != '0)
		else $error("zero match start");

	// A start position never lies beyond the text limit
	a_start_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> match_start <= pos_t'(MAX_TEXT))
		else $error("match start out of range");

	// With the output register empty the pipe always takes a byte
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> item_ready)
		else $error("input stalled with empty output");

endmodule

bind rolling_hash_substring_match rhsm_checker u_rhsm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item.valid),
	.item_ready   (item.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.match_start  (result.match_start)
);

// ----- test/rolling_hash_substring_match_tb.sv -----
// Testbench for rolling_hash_substring_match: byte streams checked against a hash predictor.
module rolling_hash_substring_match_tb;
	import rhsm_pkg::*;

	// Request kinds on req_type
	localparam bit PATTERN_BYTE = 1'b0;
	localparam bit TEXT_BYTE    = 1'b1;

	localparam int unsigned CYCLE_LIMIT = 200_000;
	localparam int unsigned DRAIN_LIMIT = 10_000;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	rhsm_in_if  byte_in();
	rhsm_out_if match_out();

	rolling_hash_substring_match u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (byte_in),
		.result (match_out)
	);

	always #1 clk = ~clk;

	// Predictor state
	hash_t pat_hash;
	len_t  pat_len;
	bit    pat_overflow;
	hash_t pow_len;
	hash_t win_hash;
	pos_t  text_count;
	byte_t history [MAX_PATTERN];

	pos_t        expected_starts[$];
	int unsigned mismatch_count = 0;
	int unsigned cycle_count    = 0;

	// Pacing controls for the sender (pace_on, burst_left) and the receiver (stall_on)
	bit          pace_on    = 1'b1;
	bit          stall_on   = 1'b1;
	int unsigned burst_left = 0;

	// Roll one accepted byte through the predictor, queue a match start if any
	function automatic void predict_match(bit is_text, byte_t b, bit first);
		longint unsigned leaving;
		longint unsigned grown;
		longint unsigned removed;
		if (is_text == PATTERN_BYTE) begin
			if (first) begin
				pat_hash     = '0;
				pat_len      = '0;
				pat_overflow = 1'b0;
				pow_len      = hash_t'(1);
			end
			win_hash   = '0;
			text_count = '0;
			if (pat_len >= MAX_PATTERN) begin
				pat_overflow = 1'b1;
			end else begin
				pat_hash = hash_t'((64'(pat_hash) * 64'(HASH_BASE) + 64'(b))
					% 64'(HASH_MOD));
				pow_len  = hash_t'((64'(pow_len) * 64'(HASH_BASE)) % 64'(HASH_MOD));
				pat_len++;
			end
			return;
		end
		if (first) begin
			win_hash   = '0;
			text_count = '0;
		end
		// saturated position: byte dropped without effect
		if (text_count >= MAX_TEXT) return;
		leaving = 0;
		if (pat_len != 0 && text_count >= pat_len) begin
			leaving = 64'(history[slot_t'(text_count - pat_len)]);
		end
		history[slot_t'(text_count)] = b;
		grown    = (64'(win_hash) * 64'(HASH_BASE) + 64'(b)) % 64'(HASH_MOD);
		removed  = (leaving * 64'(pow_len)) % 64'(HASH_MOD);
		win_hash = hash_t'((grown + 64'(HASH_MOD) - removed) % 64'(HASH_MOD));
		text_count++;
		if (pat_len != 0 && !pat_overflow && text_count >= pat_len
			&& win_hash == pat_hash) begin
			expected_starts.push_back(pos_t'(text_count - pat_len + 1));
		end
	endfunction

	function automatic byte_t pick_symbol(byte_t base, int unsigned alpha);
		if (alpha >= 256) return byte_t'($urandom);
		return byte_t'(base + $urandom_range(0, alpha - 1));
	endfunction

	// Send one byte, with bursty gaps when pacing is on
	task automatic send_byte(bit is_text, byte_t b, bit first);
		if (pace_on && burst_left == 0) begin
			byte_in.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 24);
		end
		if (burst_left > 0) burst_left--;
		byte_in.valid        <= 1'b1;
		byte_in.req_type     <= is_text;
		byte_in.data_byte    <= b;
		byte_in.first_of_run <= first;
		@(posedge clk);
		while (!byte_in.ready) @(posedge clk);
		predict_match(is_text, b, first);
	endtask

	// Hold the input idle until every queued match start has come back
	task automatic drain_matches();
		int unsigned waited;
		byte_in.valid <= 1'b0;
		waited = 0;
		while (expected_starts.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (expected_starts.size() != 0) begin
			$error("match_start expected %0d got nothing", expected_starts[0]);
			mismatch_count++;
			expected_starts.delete();
		end
	endtask

	// Field extremes, empty pattern, pattern extension, text restarts
	task automatic test_directed_cases();
		pace_on  = 1'b1;
		stall_on = 1'b1;
		// no pattern loaded yet: nothing may match
		send_byte(TEXT_BYTE, 8'h00, 1'b1);
		send_byte(TEXT_BYTE, 8'hFF, 1'b0);
		// one-byte pattern
		send_byte(PATTERN_BYTE, 8'hFF, 1'b1);
		send_byte(TEXT_BYTE, 8'hFF, 1'b1);
		send_byte(TEXT_BYTE, 8'h00, 1'b0);
		send_byte(TEXT_BYTE, 8'hFF, 1'b0);
		// two-byte pattern, then a text restart in mid-stream
		send_byte(PATTERN_BYTE, 8'h00, 1'b1);
		send_byte(PATTERN_BYTE, 8'hFF, 1'b0);
		send_byte(TEXT_BYTE, 8'h00, 1'b1);
		send_byte(TEXT_BYTE, 8'hFF, 1'b0);
		send_byte(TEXT_BYTE, 8'h00, 1'b0);
		send_byte(TEXT_BYTE, 8'hFF, 1'b0);
		send_byte(TEXT_BYTE, 8'hFF, 1'b1);
		send_byte(TEXT_BYTE, 8'h00, 1'b0);
		send_byte(TEXT_BYTE, 8'hFF, 1'b0);
		// pattern byte mid-text extends the pattern and clears the text run
		send_byte(PATTERN_BYTE, 8'h00, 1'b0);
		send_byte(TEXT_BYTE, 8'h00, 1'b0);
		send_byte(TEXT_BYTE, 8'hFF, 1'b0);
		send_byte(TEXT_BYTE, 8'h00, 1'b0);
	endtask

	// Longest legal pattern, one byte past it, and recovery
	task automatic test_pattern_limits();
		byte_t       pat[$];
		int unsigned k;
		pace_on  = 1'b1;
		stall_on = 1'b1;
		for (k = 0; k < MAX_PATTERN; k++) begin
			pat.push_back(byte_t'($urandom));
			send_byte(PATTERN_BYTE, pat[k], k == 0);
		end
		for (k = 0; k < 20; k++) send_byte(TEXT_BYTE, byte_t'($urandom), k == 0);
		for (k = 0; k < MAX_PATTERN; k++) send_byte(TEXT_BYTE, pat[k], 1'b0);
		for (k = 0; k < 40; k++) send_byte(TEXT_BYTE, pat[k], 1'b0);
		// one byte too many: matches suppressed
		send_byte(PATTERN_BYTE, byte_t'($urandom), 1'b0);
		for (k = 0; k < MAX_PATTERN; k++) send_byte(TEXT_BYTE, pat[k], k == 0);
		// a new pattern run clears the overflow
		for (k = 0; k < 3; k++) send_byte(PATTERN_BYTE, pat[k], k == 0);
		for (k = 0; k < 6; k++) send_byte(TEXT_BYTE, pat[k % 3], k == 0);
	endtask

	// Pattern loads followed by text with pasted copies, plus noise
	task automatic test_random_streams();
		byte_t       pat[$];
		byte_t       b;
		byte_t       sym_base;
		int unsigned sent;
		int unsigned plen;
		int unsigned tlen;
		int unsigned alpha;
		int unsigned k;
		bit          lead;
		bit          paused;
		sent   = 0;
		paused = 1'b0;
		while (sent < 750) begin
			if ($urandom_range(0, 4) == 0) pace_on = !pace_on;
			if ($urandom_range(0, 4) == 0) stall_on = !stall_on;
			if (!paused && sent >= 375) begin
				drain_matches();
				paused = 1'b1;
			end
			alpha    = ($urandom_range(0, 3) == 0) ? 256 : $urandom_range(2, 5);
			sym_base = byte_t'($urandom);
			plen     = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
				: $urandom_range(1, 6);
			pat.delete();
			for (k = 0; k < plen; k++) begin
				b = pick_symbol(sym_base, alpha);
				pat.push_back(b);
				send_byte(PATTERN_BYTE, b, k == 0);
			end
			sent += plen;
			tlen = $urandom_range(8, 60);
			k    = 0;
			while (k < tlen) begin
				lead = (k == 0) && ($urandom_range(0, 7) != 0);
				case ($urandom_range(0, 19))
					0, 1, 2, 3: begin
						// paste a copy of the pattern
						foreach (pat[j]) send_byte(TEXT_BYTE, pat[j], lead && j == 0);
						k += pat.size();
					end
					4: begin
						send_byte(TEXT_BYTE, pick_symbol(sym_base, alpha), 1'b1);
						k++;
					end
					5: begin
						b = pick_symbol(sym_base, alpha);
						pat.push_back(b);
						send_byte(PATTERN_BYTE, b, 1'b0);
						k++;
					end
					6: begin
						send_byte(TEXT_BYTE, byte_t'($urandom), lead);
						k++;
					end
					default: begin
						send_byte(TEXT_BYTE, pick_symbol(sym_base, alpha), lead);
						k++;
					end
				endcase
			end
			sent += k;
		end
	endtask

	// Output side: random stall stretches while enabled
	initial begin : receiver
		int unsigned stall_left;
		stall_left      = 0;
		match_out.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
			end else if (stall_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 7);
			end
			match_out.ready <= arst_n && stall_left == 0;
		end
	end

	// Compare each result transfer with the oldest queued start
	always @(posedge clk) begin : check_results
		pos_t want;
		if (arst_n && match_out.valid && match_out.ready) begin
			if (expected_starts.size() == 0) begin
				$error("match_start expected nothing got %0d", match_out.match_start);
				mismatch_count++;
			end else begin
				want = expected_starts.pop_front();
				if (match_out.match_start !== want) begin
					$error("match_start expected %0d got %0d", want, match_out.match_start);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		byte_in.valid        = 1'b0;
		byte_in.req_type     = PATTERN_BYTE;
		byte_in.data_byte    = '0;
		byte_in.first_of_run = 1'b0;
		pat_hash     = '0;
		pat_len      = '0;
		pat_overflow = 1'b0;
		pow_len      = hash_t'(1);
		win_hash     = '0;
		text_count   = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		drain_matches();
		test_pattern_limits();
		drain_matches();
		test_random_streams();
		drain_matches();
		repeat (16) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ----- rolling_hash_substring_match.f -----
design/rhsm_pkg.sv
design/rhsm_in_if.sv
design/rhsm_out_if.sv
design/rhsm_delay_line.sv
design/rolling_hash_substring_match.sv
design/rhsm_checker.sv
test/rolling_hash_substring_match_tb.sv
